// ===== hdl/assert_macros.svh =====
// Assertion macros used by the projector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PVP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PVP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pvp_pkg.sv =====
// Shared types and constants of the vertex projector.
`default_nettype none

package pvp_pkg;

   localparam int COEF_COUNT  = 22;
   localparam int SCALE_BASE  = 16;
   localparam int OFFSET_BASE = 19;

   localparam logic [16:0] MIN_CLIP_W_RESET = 17'd7;

   typedef enum logic {
      ACT_LOAD    = 1'b0,
      ACT_PROJECT = 1'b1
   } action_type;

   // Data that rides along with an item through the divider and viewport stages.
   typedef struct packed {
      logic             ok;
      logic [2:0]       neg;
      logic [3:0][31:0] clip;
   } side_type;

endpackage

`default_nettype wire

// ===== hdl/pvp_clip.sv =====
// Matrix times position: three stages of multiply, pair add and final sum.
`default_nettype none

module pvp_clip #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [3:0][31:0]  pos,
   input  logic [15:0][31:0] mat,
   output logic              out_valid,
   output logic              busy,
   output logic [3:0][31:0]  clip
);

   localparam int SW = 66;
   localparam logic [SW-1:0] BIAS = {{(SW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

   logic [2:0]             vld_ff;
   logic [2:0]             vld_in;
   logic signed [63:0]     prod_in [4][4];
   logic signed [63:0]     prod_ff [4][4];
   logic signed [64:0]     pair_in [4][2];
   logic signed [64:0]     pair_ff [4][2];
   logic [3:0][31:0]       clip_in;
   logic [3:0][31:0]       clip_ff;
   logic signed [SW-1:0]   sum     [4];
   logic signed [SW-1:0]   shifted [4];
   logic [3:0]             ovf;

   assign vld_in = {vld_ff[1:0], in_valid};

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 4; i++) begin
            prod_in[j][i] = $signed(pos[i]) * $signed(mat[j + 4*i]);
         end
         pair_in[j][0] = 65'(prod_ff[j][0]) + 65'(prod_ff[j][1]);
         pair_in[j][1] = 65'(prod_ff[j][2]) + 65'(prod_ff[j][3]);
      end
   end

   // Truncate the exact sum toward zero, then saturate to 32 bits.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sum[j]     = SW'(pair_ff[j][0]) + SW'(pair_ff[j][1]);
         shifted[j] = (sum[j] + (sum[j][SW-1] ? $signed(BIAS) : $signed({SW{1'b0}})))
                      >>> FRAC_BITS;
         ovf[j]     = !((&shifted[j][SW-1:31]) || (~|shifted[j][SW-1:31]));
         if (ovf[j]) begin
            clip_in[j] = shifted[j][SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            clip_in[j] = shifted[j][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         pair_ff <= pair_in;
         clip_ff <= clip_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign busy      = |vld_ff;
   assign clip      = clip_ff;

endmodule

`default_nettype wire

// ===== hdl/pvp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes.
`default_nettype none

module pvp_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [2:0][31+FRAC_BITS:0] num,
   input  logic [31:0]               den,
   input  pvp_pkg::side_type         side,
   output logic                      out_valid,
   output logic                      busy,
   output logic [2:0][31+FRAC_BITS:0] quo,
   output pvp_pkg::side_type         side_out
);

   localparam int NW = 32 + FRAC_BITS;

   logic                  vld_ff  [NW];
   logic [2:0][NW-1:0]    num_ff  [NW];
   logic [2:0][32:0]      rem_ff  [NW];
   logic [31:0]           den_ff  [NW];
   pvp_pkg::side_type     side_ff [NW];

   for (genvar s = 0; s < NW; s++) begin : g_step
      logic [2:0][NW-1:0] num_src;
      logic [2:0][NW-1:0] num_in;
      logic [2:0][32:0]   rem_src;
      logic [2:0][32:0]   rem_in;
      logic [2:0][32:0]   sh;
      logic [2:0][33:0]   diff;
      logic [31:0]        den_src;
      pvp_pkg::side_type  side_src;
      logic               vld_src;

      if (s == 0) begin : g_first
         assign num_src  = num;
         assign rem_src  = '0;
         assign den_src  = den;
         assign side_src = side;
         assign vld_src  = in_valid;
      end else begin : g_rest
         assign num_src  = num_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            sh[l]   = {rem_src[l][31:0], num_src[l][NW-1]};
            diff[l] = {1'b0, sh[l]} - {2'b00, den_src};
            if (!diff[l][33]) begin
               rem_in[l] = diff[l][32:0];
            end else begin
               rem_in[l] = sh[l];
            end
            num_in[l] = {num_src[l][NW-2:0], !diff[l][33]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[s]  <= num_in;
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   always_comb begin
      busy = 1'b0;
      for (int s = 0; s < NW; s++) begin
         busy = busy | vld_ff[s];
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign quo       = num_ff[NW-1];
   assign side_out  = side_ff[NW-1];

endmodule

`default_nettype wire

// ===== hdl/pvp_viewport.sv =====
// Quotient saturation, scale, offset and screen/raster conversion stages.
`default_nettype none

module pvp_viewport #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [2:0][31+FRAC_BITS:0] quo,
   input  pvp_pkg::side_type          side,
   input  logic [2:0][31:0]           scale,
   input  logic [2:0][31:0]           offset,
   output logic                       out_valid,
   output logic                       busy,
   output logic                       valid_res,
   output logic [3:0][31:0]           clip,
   output logic [31:0]                screen_x,
   output logic [31:0]                screen_y,
   output logic [31:0]                screen_z,
   output logic [15:0]                raster_x,
   output logic [15:0]                raster_y,
   output logic [23:0]                raster_z
);

   localparam int NW = 32 + FRAC_BITS;
   localparam logic [63:0] BIAS = {{(64-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
   localparam logic signed [39:0] ORIGIN = 40'sd2048 <<< FRAC_BITS;
   localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
   localparam logic [32:0] ZBIAS = 33'h7F_FFFF;

   logic [3:0]          vld_ff;
   logic [3:0]          vld_in;
   pvp_pkg::side_type   side1_ff, side2_ff, side3_ff;
   logic [2:0][31:0]    n_in, n_ff;
   logic signed [63:0]  prod_in [3];
   logic signed [63:0]  prod_ff [3];
   logic [2:0][31:0]    g_in, g_ff;
   logic signed [63:0]  t     [3];
   logic signed [64:0]  tsum  [3];
   logic [2:0]          over;

   logic signed [39:0]  dx, dy;
   logic signed [32:0]  zq;
   logic [30:0]         rxs, rys, rzs;
   logic [31:0]         sx_in, sy_in, sz_in;
   logic [15:0]         rx_in, ry_in;
   logic [23:0]         rz_in;

   logic                valid_res_ff;
   logic [3:0][31:0]    clip_ff;
   logic [31:0]         sx_ff, sy_ff, sz_ff;
   logic [15:0]         rx_ff, ry_ff;
   logic [23:0]         rz_ff;

   assign vld_in = {vld_ff[2:0], in_valid};

   // Apply the sign to the quotient magnitude and saturate to 32 bits.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (side.neg[l]) begin
            over[l] = (|quo[l][NW-1:32]) || (quo[l][31] && (|quo[l][30:0]));
            n_in[l] = over[l] ? 32'h8000_0000 : (~quo[l][31:0] + 32'd1);
         end else begin
            over[l] = |quo[l][NW-1:31];
            n_in[l] = over[l] ? 32'h7FFF_FFFF : {1'b0, quo[l][30:0]};
         end
         prod_in[l] = $signed(n_ff[l]) * $signed(scale[l]);
      end
   end

   // Truncate the scaled value toward zero, add the offset, saturate.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         t[l]    = (prod_ff[l] + (prod_ff[l][63] ? $signed(BIAS) : 64'sd0)) >>> FRAC_BITS;
         tsum[l] = 65'(t[l]) + 65'($signed(offset[l]));
         if ((&tsum[l][64:31]) || (~|tsum[l][64:31])) begin
            g_in[l] = tsum[l][31:0];
         end else begin
            g_in[l] = tsum[l][64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
      end
   end

   // Screen and raster conversions from the viewport values.
   always_comb begin
      dx = 40'($signed(g_ff[0])) - ORIGIN;
      dy = 40'($signed(g_ff[1])) - ORIGIN;
      if ((&dx[39:31]) || (~|dx[39:31])) begin
         sx_in = dx[31:0];
      end else begin
         sx_in = dx[39] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if ((&dy[39:31]) || (~|dy[39:31])) begin
         sy_in = dy[31:0];
      end else begin
         sy_in = dy[39] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end

      zq    = (33'($signed(g_ff[2])) + (g_ff[2][31] ? $signed(ZBIAS) : 33'sd0)) >>> 23;
      sz_in = ONE - zq[31:0];

      rxs = g_ff[0][30:0] >> (FRAC_BITS - 4);
      rys = g_ff[1][30:0] >> (FRAC_BITS - 4);
      rzs = g_ff[2][30:0] >> FRAC_BITS;
      if (g_ff[0][31]) begin
         rx_in = '0;
      end else begin
         rx_in = (|rxs[30:16]) ? 16'hFFFF : rxs[15:0];
      end
      if (g_ff[1][31]) begin
         ry_in = '0;
      end else begin
         ry_in = (|rys[30:16]) ? 16'hFFFF : rys[15:0];
      end
      if (g_ff[2][31]) begin
         rz_in = '0;
      end else begin
         rz_in = (|rzs[30:24]) ? 24'hFF_FFFF : rzs[23:0];
      end

      if (!side3_ff.ok) begin
         sx_in = '0;
         sy_in = '0;
         sz_in = '0;
         rx_in = '0;
         ry_in = '0;
         rz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff     <= side;
         n_ff         <= n_in;
         side2_ff     <= side1_ff;
         prod_ff      <= prod_in;
         side3_ff     <= side2_ff;
         g_ff         <= g_in;
         valid_res_ff <= side3_ff.ok;
         clip_ff      <= side3_ff.clip;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sz_ff        <= sz_in;
         rx_ff        <= rx_in;
         ry_ff        <= ry_in;
         rz_ff        <= rz_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign busy      = |vld_ff;
   assign valid_res = valid_res_ff;
   assign clip      = clip_ff;
   assign screen_x  = sx_ff;
   assign screen_y  = sy_ff;
   assign screen_z  = sz_ff;
   assign raster_x  = rx_ff;
   assign raster_y  = ry_ff;
   assign raster_z  = rz_ff;

endmodule

`default_nettype wire

// ===== hdl/perspective_vertex_projector_unit.sv =====
// Top level of the perspective vertex projector: store, control and pipeline.
//
// The request channel (req_valid/req_stall) carries two kinds of item. A load
// item writes one of 22 coefficient words: the column-major 4x4 matrix, then
// three scale and three offset words. A project item carries a homogeneous
// position and produces exactly one result item on the rsp_ channel.
// Projects flow at one item per clock while no result is stalled. The pipeline
// holds 40 + FRAC_BITS register stages (56 at the default): three matrix
// stages, one divider setup stage, one divider stage per quotient bit
// (32 + FRAC_BITS), and four viewport stages ending in the output register.
// A load item is held off with req_stall while any project is in flight, so
// that every project sees the coefficients that were current when it entered.
// The threshold register min_clip_w is written through csr_wr_en/csr_wr_data.
// Reset clears all valid bits and sets min_clip_w to 7; the coefficient store
// is not cleared and must be loaded before the first project.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises; nothing is lost or repeated.
`default_nettype none
`include "assert_macros.svh"

module perspective_vertex_projector_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [4:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_pos_w,
   input  logic               csr_wr_en,
   input  logic [16:0]        csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_valid_res,
   output logic signed [31:0] rsp_clip_x,
   output logic signed [31:0] rsp_clip_y,
   output logic signed [31:0] rsp_clip_z,
   output logic signed [31:0] rsp_clip_w,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   output logic signed [31:0] rsp_screen_z,
   output logic [15:0]        rsp_raster_x,
   output logic [15:0]        rsp_raster_y,
   output logic [23:0]        rsp_raster_z
);

   localparam int NW = 32 + FRAC_BITS;

   // The pipeline advances as one unit unless a finished item is waiting.
   logic                advance;
   logic                busy;
   logic                is_load;
   logic                load_acc;
   logic                load_wr;
   logic                proj_in;
   logic                rsp_blank;

   logic [31:0]         coef_ff [pvp_pkg::COEF_COUNT];
   logic [16:0]         min_clip_w_ff;
   logic [16:0]         min_clip_w_in;

   logic [15:0][31:0]   mat;
   logic [2:0][31:0]    scale;
   logic [2:0][31:0]    offset;
   logic [3:0][31:0]    pos;

   logic                clip_vld;
   logic                clip_busy;
   logic [3:0][31:0]    clip;

   // Divider setup stage.
   logic                prep_vld_ff;
   logic [2:0][NW-1:0]  prep_num_ff, prep_num_in;
   logic [31:0]         prep_den_ff;
   pvp_pkg::side_type   prep_side_ff, prep_side_in;

   logic                div_vld;
   logic                div_busy;
   logic [2:0][NW-1:0]  div_quo;
   pvp_pkg::side_type   div_side;

   logic                vp_busy;
   logic [3:0][31:0]    vp_clip;

   assign is_load   = (req_action == pvp_pkg::ACT_LOAD);
   assign busy      = clip_busy | prep_vld_ff | div_busy | vp_busy;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance || (req_valid && is_load && busy);
   assign load_acc  = req_valid && !req_stall && is_load;
   assign load_wr   = load_acc && (req_coef_index < 5'(pvp_pkg::COEF_COUNT));
   assign proj_in   = req_valid && !req_stall && !is_load;
   assign rsp_blank = (rsp_screen_x == 32'sd0) && (rsp_raster_z == 24'd0);

   // Coefficient store: written by load items only, no reset.
   always_ff @(posedge clock) begin
      if (load_wr) begin
         coef_ff[req_coef_index] <= req_coef_value;
      end
   end

   assign min_clip_w_in = csr_wr_en ? csr_wr_data : min_clip_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_clip_w_ff <= pvp_pkg::MIN_CLIP_W_RESET;
      end else begin
         min_clip_w_ff <= min_clip_w_in;
      end
   end

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         mat[k] = coef_ff[k];
      end
      for (int l = 0; l < 3; l++) begin
         scale[l]  = coef_ff[pvp_pkg::SCALE_BASE + l];
         offset[l] = coef_ff[pvp_pkg::OFFSET_BASE + l];
      end
   end

   assign pos = {req_pos_w, req_pos_z, req_pos_y, req_pos_x};

   pvp_clip #(
      .FRAC_BITS (FRAC_BITS)
   ) u_clip (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (proj_in),
      .pos       (pos),
      .mat       (mat),
      .out_valid (clip_vld),
      .busy      (clip_busy),
      .clip      (clip)
   );

   // Validity test against the threshold and conversion to sign and magnitude;
   // the magnitude is pre-shifted by FRAC_BITS to form the dividend.
   always_comb begin
      prep_side_in.ok   = $signed(clip[3]) > $signed({15'b0, min_clip_w_ff});
      prep_side_in.clip = clip;
      for (int l = 0; l < 3; l++) begin
         prep_side_in.neg[l] = clip[l][31];
         prep_num_in[l] = {(clip[l][31] ? (~clip[l] + 32'd1) : clip[l]),
                           {FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else if (advance) begin
         prep_vld_ff <= clip_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_num_ff  <= prep_num_in;
         prep_den_ff  <= clip[3];
         prep_side_ff <= prep_side_in;
      end
   end

   pvp_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (prep_vld_ff),
      .num       (prep_num_ff),
      .den       (prep_den_ff),
      .side      (prep_side_ff),
      .out_valid (div_vld),
      .busy      (div_busy),
      .quo       (div_quo),
      .side_out  (div_side)
   );

   pvp_viewport #(
      .FRAC_BITS (FRAC_BITS)
   ) u_viewport (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (div_vld),
      .quo       (div_quo),
      .side      (div_side),
      .scale     (scale),
      .offset    (offset),
      .out_valid (rsp_valid),
      .busy      (vp_busy),
      .valid_res (rsp_valid_res),
      .clip      (vp_clip),
      .screen_x  (rsp_screen_x),
      .screen_y  (rsp_screen_y),
      .screen_z  (rsp_screen_z),
      .raster_x  (rsp_raster_x),
      .raster_y  (rsp_raster_y),
      .raster_z  (rsp_raster_z)
   );

   assign rsp_clip_x = vp_clip[0];
   assign rsp_clip_y = vp_clip[1];
   assign rsp_clip_z = vp_clip[2];
   assign rsp_clip_w = vp_clip[3];

   // A load must never be taken while a project is still in the pipeline.
   `PVP_ASSERT_IMP(a_load_idle, clock, reset, load_acc, !busy, "load taken while busy")
   // A load item never enters the pipeline, so it leaves no activity behind.
   `PVP_ASSERT_NXT(a_load_no_result, clock, reset, load_acc, !busy, "load left activity")
   // An invalid vertex carries zero screen and raster fields, checked on screen_x and raster_z.
   `PVP_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && !rsp_valid_res, rsp_blank, "bad invalid")

endmodule

`default_nettype wire
